>>> sv/ppp_pkg.sv
package ppp_pkg;

    localparam int FRAC_BITS_DEF = 10;
    localparam int NUM_REGS = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TRIG_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_SINE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_COSINE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_SINE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_COSINE = 3'd6;

    localparam int SCREEN_CX = 160;
    localparam int SCREEN_CY = 100;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] view_x;
        logic signed [15:0] view_y;
        logic signed [15:0] view_z;
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic               zero_depth;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0]       cam_x;
        logic signed [15:0]       cam_y;
        logic signed [15:0]       cam_z;
        logic signed [TRIG_W-1:0] yaw_s;
        logic signed [TRIG_W-1:0] yaw_c;
        logic signed [TRIG_W-1:0] pit_s;
        logic signed [TRIG_W-1:0] pit_c;
    } cam_cfg_t;

    // Scaled product a*b/2^frac, truncated toward zero, wrapped to 16 bits.
    function automatic logic signed [15:0] fx_scale(input logic signed [27:0] p,
                                                     input int frac);
        logic signed [27:0] adj;
        logic signed [27:0] q;
        begin
            adj = p;
            if (p < 0) begin
                adj = p + 28'(((1 << frac) - 1));
            end
            q = adj >>> frac;
            return q[15:0];
        end
    endfunction

endpackage

>>> sv/ppp_divider.sv
// Pipelined restoring divider, one quotient bit per stage, signed toward zero.
module ppp_divider #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16,
    parameter int TAG_W = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [NUM_W-1:0] in_num,
    input  logic signed [DEN_W-1:0] in_den,
    input  logic [TAG_W-1:0]        in_tag,
    output logic                    out_valid,
    output logic signed [15:0]      out_quo,
    output logic [TAG_W-1:0]        out_tag
);

    localparam int REM_W = DEN_W + 1;

    logic [NUM_W:0]       vld_reg;
    logic [NUM_W-1:0]     num_reg [NUM_W+1];
    logic [DEN_W-1:0]     den_reg [NUM_W+1];
    logic [REM_W-1:0]     rem_reg [NUM_W+1];
    logic [NUM_W-1:0]     quo_reg [NUM_W+1];
    logic                 neg_reg [NUM_W+1];
    logic [TAG_W-1:0]     tag_reg [NUM_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NUM_W-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg[0] <= in_num[NUM_W-1] ? NUM_W'(-in_num) : NUM_W'(in_num);
            den_reg[0] <= in_den[DEN_W-1] ? DEN_W'(-in_den) : DEN_W'(in_den);
            neg_reg[0] <= in_num[NUM_W-1] ^ in_den[DEN_W-1];
            rem_reg[0] <= '0;
            quo_reg[0] <= '0;
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar i = 0; i < NUM_W; i++) begin : g_step
        logic [REM_W:0] trial;
        logic [REM_W:0] shifted;
        assign shifted = {rem_reg[i], num_reg[i][NUM_W-1-i]};
        assign trial = shifted - {2'b0, den_reg[i]};
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!trial[REM_W]) begin
                    rem_reg[i+1] <= trial[REM_W-1:0];
                end else begin
                    rem_reg[i+1] <= shifted[REM_W-1:0];
                end
                quo_reg[i+1] <= {quo_reg[i][NUM_W-2:0], ~trial[REM_W]};
                num_reg[i+1] <= num_reg[i];
                den_reg[i+1] <= den_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    logic [NUM_W-1:0] q_signed;
    assign q_signed = neg_reg[NUM_W] ? -quo_reg[NUM_W] : quo_reg[NUM_W];
    assign out_valid = vld_reg[NUM_W];
    assign out_quo = q_signed[15:0];
    assign out_tag = tag_reg[NUM_W];

endmodule

>>> sv/ppp_rotate.sv
// Camera offset and yaw/pitch rotation over five register stages.
module ppp_rotate #(
    parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  ppp_pkg::in_item_t   in_item,
    input  ppp_pkg::cam_cfg_t   cfg,
    output logic                out_valid,
    output logic signed [15:0]  out_x,
    output logic signed [15:0]  out_y,
    output logic signed [15:0]  out_z
);

    logic [4:0] vld_reg;
    logic signed [15:0] x0_reg, y0_reg, z0_reg;
    logic signed [27:0] pxc_reg, pzs_reg, pzc_reg, pxs_reg;
    logic signed [15:0] y1_reg;
    logic signed [15:0] x1_reg, z1_reg, y1b_reg;
    logic signed [27:0] pyc_reg, pzps_reg, pzpc_reg, pyps_reg;
    logic signed [15:0] x1b_reg;
    logic signed [15:0] x2_reg, y2_reg, z2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg <= in_item.point_x - cfg.cam_x;
            y0_reg <= in_item.point_y - cfg.cam_y;
            z0_reg <= in_item.point_z - cfg.cam_z;

            pxc_reg <= 28'(x0_reg * cfg.yaw_c);
            pzs_reg <= 28'(z0_reg * cfg.yaw_s);
            pzc_reg <= 28'(z0_reg * cfg.yaw_c);
            pxs_reg <= 28'(x0_reg * cfg.yaw_s);
            y1_reg <= y0_reg;

            x1_reg <= ppp_pkg::fx_scale(pxc_reg, FRAC_BITS)
                    - ppp_pkg::fx_scale(pzs_reg, FRAC_BITS);
            z1_reg <= ppp_pkg::fx_scale(pzc_reg, FRAC_BITS)
                    + ppp_pkg::fx_scale(pxs_reg, FRAC_BITS);
            y1b_reg <= y1_reg;

            pyc_reg <= 28'(y1b_reg * cfg.pit_c);
            pzps_reg <= 28'(z1_reg * cfg.pit_s);
            pzpc_reg <= 28'(z1_reg * cfg.pit_c);
            pyps_reg <= 28'(y1b_reg * cfg.pit_s);
            x1b_reg <= x1_reg;

            y2_reg <= ppp_pkg::fx_scale(pyc_reg, FRAC_BITS)
                    - ppp_pkg::fx_scale(pzps_reg, FRAC_BITS);
            z2_reg <= ppp_pkg::fx_scale(pzpc_reg, FRAC_BITS)
                    + ppp_pkg::fx_scale(pyps_reg, FRAC_BITS);
            x2_reg <= x1b_reg;
        end
    end

    assign out_valid = vld_reg[4];
    assign out_x = x2_reg;
    assign out_y = y2_reg;
    assign out_z = z2_reg;

endmodule

>>> sv/ppp_project.sv
// Perspective divide, divide by three and screen offset.
module ppp_project #(
    parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [15:0]  in_x,
    input  logic signed [15:0]  in_y,
    input  logic signed [15:0]  in_z,
    output logic                out_valid,
    output ppp_pkg::out_item_t  out_item
);

    localparam int NUM_W = 16 + FRAC_BITS + 1;
    localparam int TAG_W = 16 * 3;

    logic signed [NUM_W-1:0] nx, ny;
    logic signed [15:0] den;
    logic dvx, dvy;
    logic signed [15:0] qx, qy;
    logic [TAG_W-1:0] tagx, tagy;

    assign nx = NUM_W'(in_x) <<< FRAC_BITS;
    assign ny = NUM_W'(in_y) <<< FRAC_BITS;
    assign den = (in_z == 16'sd0) ? 16'sd1 : in_z;

    ppp_divider #(.NUM_W(NUM_W), .DEN_W(16), .TAG_W(TAG_W)) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(in_valid),
        .in_num(nx), .in_den(den), .in_tag({in_x, in_y, in_z}),
        .out_valid(dvx), .out_quo(qx), .out_tag(tagx)
    );

    ppp_divider #(.NUM_W(NUM_W), .DEN_W(16), .TAG_W(1)) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(in_valid),
        .in_num(ny), .in_den(den), .in_tag(1'b0),
        .out_valid(dvy), .out_quo(qy), .out_tag(tagy[0])
    );
    assign tagy[TAG_W-1:1] = '0;

    // Divide by three through a reciprocal multiply on magnitudes.
    logic v1_reg, v2_reg;
    logic [TAG_W-1:0] t1_reg, t2_reg;
    logic [15:0] ax_reg, ay_reg;
    logic sx_reg, sy_reg;
    logic [33:0] mx_reg, my_reg;
    logic sx2_reg, sy2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= dvx;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg <= qx[15] ? 16'(-qx) : 16'(qx);
            ay_reg <= qy[15] ? 16'(-qy) : 16'(qy);
            sx_reg <= qx[15];
            sy_reg <= qy[15];
            t1_reg <= tagx | (tagy & '0);
            mx_reg <= 34'(ax_reg) * 34'd43691;
            my_reg <= 34'(ay_reg) * 34'd43691;
            sx2_reg <= sx_reg;
            sy2_reg <= sy_reg;
            t2_reg <= t1_reg;
        end
    end

    logic [15:0] dx, dy;
    logic signed [15:0] zz;
    assign dx = 16'(mx_reg >> 17);
    assign dy = 16'(my_reg >> 17);
    assign zz = t2_reg[15:0];

    always_comb begin
        out_item.view_x = t2_reg[47:32];
        out_item.view_y = t2_reg[31:16];
        out_item.view_z = zz;
        out_item.zero_depth = (zz == 16'sd0);
        out_item.pixel_x = (sx2_reg ? 16'(-dx) : dx) + 16'(ppp_pkg::SCREEN_CX);
        out_item.pixel_y = (sy2_reg ? 16'(-dy) : dy) + 16'(ppp_pkg::SCREEN_CY);
        if (zz == 16'sd0) begin
            out_item.pixel_x = '0;
            out_item.pixel_y = '0;
        end
    end

    assign out_valid = v2_reg;

`ifndef ASSERT_OFF
    a_div_lanes: assert property (@(posedge aclk) disable iff (!aresetn) dvx == dvy)
        else $error("divider lanes out of step");
    a_zero_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_item.zero_depth |-> out_item.pixel_x == 16'sd0)
        else $error("zero depth screen not cleared");
    a_valid_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        en && v1_reg |=> v2_reg)
        else $error("valid lost in output stage");
`endif

endmodule

>>> sv/point_perspective_projection_top.sv
// Throughput: one point per cycle; the rotation multipliers and the bit-per-stage
// dividers are fully pipelined and the whole pipe advances when the output is free.
// Reset: synchronous active-low aresetn clears all valid bits and loads the camera
// registers with zero position, zero sines and cosines of 1024.
module point_perspective_projection_top #(
    parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  ppp_pkg::in_item_t                      s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output ppp_pkg::out_item_t                     m_data,
    input  logic                                   cfg_we,
    input  logic [ppp_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [ppp_pkg::CFG_DATA_W-1:0]         cfg_data
);

    ppp_pkg::cam_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{cam_x: '0, cam_y: '0, cam_z: '0, yaw_s: '0,
                         yaw_c: 12'sd1024, pit_s: '0, pit_c: 12'sd1024};
        end else if (cfg_we) begin
            case (cfg_index)
                ppp_pkg::REG_CAMERA_X: cfg_reg.cam_x <= cfg_data;
                ppp_pkg::REG_CAMERA_Y: cfg_reg.cam_y <= cfg_data;
                ppp_pkg::REG_CAMERA_Z: cfg_reg.cam_z <= cfg_data;
                ppp_pkg::REG_YAW_SINE: cfg_reg.yaw_s <= cfg_data[ppp_pkg::TRIG_W-1:0];
                ppp_pkg::REG_YAW_COSINE: cfg_reg.yaw_c <= cfg_data[ppp_pkg::TRIG_W-1:0];
                ppp_pkg::REG_PITCH_SINE: cfg_reg.pit_s <= cfg_data[ppp_pkg::TRIG_W-1:0];
                ppp_pkg::REG_PITCH_COSINE: cfg_reg.pit_c <= cfg_data[ppp_pkg::TRIG_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipe advances whenever the output register is empty or being drained.
    logic en;
    logic rv;
    logic signed [15:0] rx, ry, rz;
    logic pv;
    ppp_pkg::out_item_t pitem;

    assign en = !m_valid || m_ready;
    assign s_ready = en;

    ppp_rotate #(.FRAC_BITS(FRAC_BITS)) u_rot (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid && s_ready), .in_item(s_data), .cfg(cfg_reg),
        .out_valid(rv), .out_x(rx), .out_y(ry), .out_z(rz)
    );

    ppp_project #(.FRAC_BITS(FRAC_BITS)) u_proj (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(rv), .in_x(rx), .in_y(ry), .in_z(rz),
        .out_valid(pv), .out_item(pitem)
    );

    logic m_valid_reg;
    ppp_pkg::out_item_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= pv;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= pitem;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

`ifndef ASSERT_OFF
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");
    a_zero_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.zero_depth == (m_data.view_z == 16'sd0))
        else $error("zero depth flag mismatch");
`endif

endmodule
